FILE: rtl/lft_pkg.sv
package lft_pkg;

   localparam int FUNC_W    = 2;
   localparam int ADDR_W    = 32;
   localparam int TIME_W    = 48;
   localparam int BLOCK_W   = 49;
   localparam int COUNT_W   = 8;
   localparam int LEN_W     = 32;
   localparam int RETRY_W   = 23;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam int SOURCE_ENTRIES_DEF = 8;

   localparam logic [COUNT_W-1:0] FAILURE_LIMIT_RST = 8'd5;
   localparam logic [LEN_W-1:0]   WINDOW_LENGTH_RST = 32'd60000;
   localparam logic [LEN_W-1:0]   BLOCK_LENGTH_RST  = 32'd60000;

   localparam logic [RETRY_W-1:0] RETRY_MAX = 23'd4294968;
   localparam logic [BLOCK_W-1:0] SAT_LEFT  = 49'd4294968000;
   localparam int                 ROUND_W   = 33;
   localparam logic [ROUND_W-1:0] ROUND_UP  = 33'd999;
   localparam int                 QUOT_W    = 30;
   localparam int                 RECIP_W   = 31;
   localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;
   localparam int                 RECIP_SHIFT = 37;
   localparam int                 PROD_W    = QUOT_W + RECIP_W;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CHECK   = 2'd0,
      FUNC_FAILURE = 2'd1,
      FUNC_SUCCESS = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAILURE_LIMIT = 2'd0,
      CSR_WINDOW_LENGTH = 2'd1,
      CSR_BLOCK_LENGTH  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic [COUNT_W-1:0] failures;
      logic [TIME_W-1:0]  window_start;
      logic [BLOCK_W-1:0] blocked_until;
      logic [TIME_W-1:0]  last_seen;
   } entry_type;

endpackage

FILE: rtl/lft_if.sv
interface lft_req_if;
   logic                          valid;
   logic                          ready;
   logic [lft_pkg::FUNC_W-1:0]    func;
   logic [lft_pkg::ADDR_W-1:0]    source_address;
   logic [lft_pkg::TIME_W-1:0]    time_ms;

   modport source (output valid, func, source_address, time_ms, input ready);
   modport sink   (input valid, func, source_address, time_ms, output ready);
endinterface

interface lft_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          allowed;
   logic [lft_pkg::RETRY_W-1:0]   retry_after_s;
   logic                          entry_found;

   modport source (output valid, allowed, retry_after_s, entry_found, input ready);
   modport sink   (input valid, allowed, retry_after_s, entry_found, output ready);
endinterface

interface lft_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lft_pkg::CSR_IDX_W-1:0] index;
   logic [lft_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/login_failure_throttle.sv
// channel   dir  payload                                   handshake
// req_bus   in   func, source_address, time_ms             valid/ready
// rsp_bus   out  allowed, retry_after_s, entry_found       valid/ready
// csr_bus   in   index, data                               valid/ready, always ready
//
// One item at a time: a scan of all SOURCE_ENTRIES entries, one entry read per cycle,
// then one update, plus a write for a failure or round and scale for a check.
// Synchronous active-high reset clears the valid bits of all entries and loads
// register defaults; no clearing pass. A result waits in the output register
// while the next item may already be accepted.
module login_failure_throttle #(
   parameter int SOURCE_ENTRIES = lft_pkg::SOURCE_ENTRIES_DEF
) (
   input logic        clock,
   input logic        reset,
   lft_req_if.sink    req_bus,
   lft_rsp_if.source  rsp_bus,
   lft_csr_if.sink    csr_bus
);
   import lft_pkg::*;

   localparam int IDX_W = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(SOURCE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SOURCE_ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_UPDATE, ST_FAIL, ST_ROUND, ST_SCALE, ST_DONE
   } state_type;

   state_type            state_ff;
   logic [FUNC_W-1:0]    func_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [CNT_W-1:0]     issue_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   entry_type            rd_data_ff;
   logic [SOURCE_ENTRIES-1:0] used_ff;

   logic                 hit_ff;
   logic [IDX_W-1:0]     hit_idx_ff;
   entry_type            hit_entry_ff;
   logic                 free_ff;
   logic [IDX_W-1:0]     free_idx_ff;
   logic [IDX_W-1:0]     oldest_idx_ff;
   logic [TIME_W-1:0]    oldest_ls_ff;

   logic [IDX_W-1:0]     slot_ff;
   entry_type            entry_ff;
   logic                 restart_ff;
   logic                 blocked_ff;
   logic [BLOCK_W-1:0]   left_ff;
   logic                 sat_ff;
   logic [QUOT_W-1:0]    quot_ff;
   logic [PROD_W-1:0]    prod_ff;

   logic [COUNT_W-1:0]   failure_limit_ff;
   logic [LEN_W-1:0]     window_length_ms_ff;
   logic [LEN_W-1:0]     block_length_ms_ff;

   logic                 rsp_valid_ff;
   logic                 allowed_ff;
   logic [RETRY_W-1:0]   retry_ff;
   logic                 found_ff;

   entry_type            entry_mem [SOURCE_ENTRIES];

   logic                 req_acc;
   logic                 scan_used;
   logic [TIME_W-1:0]    scan_ls;
   logic                 scan_hit;
   logic [BLOCK_W-1:0]   window_diff;
   logic                 restart_in;
   logic [COUNT_W-1:0]   fail_count;
   logic                 fail_block;
   entry_type            fail_entry;
   logic [ROUND_W-1:0]   round_sum;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;
   entry_type            mem_wd;
   logic                 func_known;

   assign req_acc       = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.allowed       = allowed_ff;
   assign rsp_bus.retry_after_s = retry_ff;
   assign rsp_bus.entry_found   = found_ff;

   assign func_known = (func_ff == FUNC_CHECK) || (func_ff == FUNC_FAILURE) ||
                       (func_ff == FUNC_SUCCESS);

   // scan compare
   assign scan_used = used_ff[rd_idx_ff];
   assign scan_ls   = scan_used ? rd_data_ff.last_seen : '0;
   assign scan_hit  = scan_used && (rd_data_ff.address == addr_ff);

   // window restart on a hit
   assign window_diff = {1'b0, now_ff} - {1'b0, hit_entry_ff.window_start};
   assign restart_in  = hit_ff &&
                        ($signed(window_diff) > $signed(BLOCK_W'(window_length_ms_ff)));

   // failure count and block
   assign fail_count = (restart_ff ? '0 : entry_ff.failures) + COUNT_W'(1);
   assign fail_block = (fail_count >= failure_limit_ff);

   always_comb begin
      fail_entry               = entry_ff;
      fail_entry.address       = addr_ff;
      fail_entry.last_seen     = now_ff;
      fail_entry.window_start  = restart_ff ? now_ff : entry_ff.window_start;
      fail_entry.failures      = fail_block ? '0 : fail_count;
      fail_entry.blocked_until = fail_block ?
                                 ({1'b0, now_ff} + BLOCK_W'(block_length_ms_ff)) :
                                 entry_ff.blocked_until;
   end

   assign round_sum = left_ff[ROUND_W-1:0] + ROUND_UP;

   always_comb begin
      mem_we           = 1'b0;
      mem_wa           = hit_idx_ff;
      mem_wd           = hit_entry_ff;
      mem_wd.last_seen = now_ff;
      if (state_ff == ST_UPDATE && func_ff == FUNC_CHECK && hit_ff) begin
         mem_we = 1'b1;
      end
      if (state_ff == ST_FAIL) begin
         mem_we = 1'b1;
         mem_wa = slot_ff;
         mem_wd = fail_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= entry_mem[issue_ff[IDX_W-1:0]];
      rd_idx_ff  <= issue_ff[IDX_W-1:0];
   end

   // track hit, first free and least recently seen entry
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (req_acc) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (scan_hit && !hit_ff) begin
            hit_ff       <= 1'b1;
            hit_idx_ff   <= rd_idx_ff;
            hit_entry_ff <= rd_data_ff;
         end
         if (!scan_used && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
         if (rd_idx_ff == '0 || scan_ls < oldest_ls_ff) begin
            oldest_idx_ff <= rd_idx_ff;
            oldest_ls_ff  <= scan_ls;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         failure_limit_ff    <= FAILURE_LIMIT_RST;
         window_length_ms_ff <= WINDOW_LENGTH_RST;
         block_length_ms_ff  <= BLOCK_LENGTH_RST;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_FAILURE_LIMIT: failure_limit_ff    <= csr_bus.data[COUNT_W-1:0];
            CSR_WINDOW_LENGTH: window_length_ms_ff <= csr_bus.data[LEN_W-1:0];
            CSR_BLOCK_LENGTH:  block_length_ms_ff  <= csr_bus.data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         used_ff      <= '0;
         blocked_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= (state_ff == ST_SCAN) && (issue_ff != LAST_CNT);
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_bus.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  func_ff    <= req_bus.func;
                  addr_ff    <= req_bus.source_address;
                  now_ff     <= req_bus.time_ms;
                  issue_ff   <= '0;
                  blocked_ff <= 1'b0;
                  state_ff   <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (issue_ff == LAST_CNT) begin
                  state_ff <= ST_UPDATE;
               end else begin
                  issue_ff  <= issue_ff + CNT_W'(1);
               end
            end
            ST_UPDATE: begin
               case (func_ff)
                  FUNC_CHECK: begin
                     blocked_ff <= hit_ff && ({1'b0, now_ff} < hit_entry_ff.blocked_until);
                     left_ff    <= hit_entry_ff.blocked_until - {1'b0, now_ff};
                     state_ff   <= ST_ROUND;
                  end
                  FUNC_FAILURE: begin
                     restart_ff <= restart_in;
                     if (hit_ff) begin
                        slot_ff  <= hit_idx_ff;
                        entry_ff <= hit_entry_ff;
                     end else begin
                        slot_ff  <= free_ff ? free_idx_ff : oldest_idx_ff;
                        entry_ff <= '{address: addr_ff, failures: '0, window_start: now_ff,
                                      blocked_until: '0, last_seen: now_ff};
                     end
                     state_ff <= ST_FAIL;
                  end
                  FUNC_SUCCESS: begin
                     if (hit_ff) begin
                        used_ff[hit_idx_ff] <= 1'b0;
                     end
                     state_ff <= ST_DONE;
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_FAIL: begin
               used_ff[slot_ff] <= 1'b1;
               state_ff         <= ST_DONE;
            end
            ST_ROUND: begin
               sat_ff   <= (left_ff > SAT_LEFT);
               quot_ff  <= round_sum[ROUND_W-1:ROUND_W-QUOT_W];
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               prod_ff  <= PROD_W'(quot_ff) * PROD_W'(RECIP_125);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  allowed_ff   <= !blocked_ff;
                  found_ff     <= hit_ff && func_known;
                  if (!blocked_ff) begin
                     retry_ff <= '0;
                  end else if (sat_ff) begin
                     retry_ff <= RETRY_MAX;
                  end else begin
                     retry_ff <= prod_ff[RECIP_SHIFT +: RETRY_W];
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_SCAN)
      else $error("accepted item did not start a scan");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_UPDATE || state_ff == ST_FAIL))
      else $error("entry write outside update");

   a_block_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !allowed_ff) |-> found_ff)
      else $error("blocked result without table entry");

   a_retry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (allowed_ff == (retry_ff == '0)))
      else $error("retry time disagrees with allowed");

endmodule
